>>> rtl/cscrw_pkg.sv
// Shared types, command codes and the CRC helper for the config stream CRC rewriter.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package cscrw_pkg;

  // Stream framing
  localparam logic [31:0] PREAMBLE = 32'h7eaa997e;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hffff;

  // Command codes (high nibble of a command byte)
  localparam logic [3:0] CMD_CONTROL = 4'h0;
  localparam logic [3:0] CMD_BANK    = 4'h1;
  localparam logic [3:0] CMD_CRC     = 4'h2;
  localparam logic [3:0] CMD_FREQ    = 4'h5;
  localparam logic [3:0] CMD_WIDTH   = 4'h6;
  localparam logic [3:0] CMD_HEIGHT  = 4'h7;
  localparam logic [3:0] CMD_OFFSET  = 4'h8;
  localparam logic [3:0] CMD_FLAGS   = 4'h9;

  // Control payloads
  localparam logic [31:0] CTL_CRAM      = 32'd1;
  localparam logic [31:0] CTL_BRAM      = 32'd3;
  localparam logic [31:0] CTL_CRC_RESET = 32'd5;
  localparam logic [31:0] CTL_WAKEUP    = 32'd6;

  // Frequency range limit and flags payloads
  localparam logic [31:0] FREQ_MAX       = 32'd2;
  localparam logic [31:0] FLG_NONE       = 32'd0;
  localparam logic [31:0] FLG_NOSLEEP    = 32'd1;
  localparam logic [31:0] FLG_WARM       = 32'd32;
  localparam logic [31:0] FLG_WARM_NOSLP = 32'd33;

  // Warning codes
  localparam logic [2:0] WARN_NONE      = 3'd0;
  localparam logic [2:0] WARN_CRAM_TRL  = 3'd1;
  localparam logic [2:0] WARN_BRAM_TRL  = 3'd2;
  localparam logic [2:0] WARN_BAD_CMD   = 3'd3;
  localparam logic [2:0] WARN_BAD_CTL   = 3'd4;
  localparam logic [2:0] WARN_BAD_FREQ  = 3'd5;
  localparam logic [2:0] WARN_BAD_FLAGS = 3'd6;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // One queued item: which bytes to emit plus the status shown on them
  typedef struct packed {
    logic       echo;      // emit data
    logic       crc_hi;    // emit CRC high byte
    logic       crc_lo;    // emit CRC low byte
    logic       pad;       // emit zero pad byte
    logic       crc_rst;   // load CRC init after the echo
    logic [7:0] data;
    logic [2:0] warn;
    logic [1:0] freq;
    logic       warm_boot;
    logic       no_sleep;
    logic       done;
  } cscrw_entry_t;

  // CRC-16-CCITT over one byte, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        top;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      top = c[15] ^ b[i];
      c   = {c[14:0], 1'b0} ^ (top ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

endpackage

>>> rtl/cscrw_queue.sv
// Short register queue that decouples the command front from the output back.
// Depends on cscrw_pkg for the entry type and depth.
`timescale 1ns / 1ps

module cscrw_queue
  import cscrw_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  cscrw_entry_t push_entry,
  input  logic         pop,
  output cscrw_entry_t head,
  output logic         empty,
  output logic         full
);

  cscrw_entry_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0]       wr_ptr_r;
  logic [QPTR_W-1:0]       rd_ptr_r;
  logic [QCNT_W-1:0]       count_r;

  assign empty = (count_r == '0);
  assign full  = (count_r == QCNT_W'(QDEPTH));
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

>>> rtl/cscrw_front.sv
// Front part: preamble search, command decode, payload gathering and run tracking.
// Depends on cscrw_pkg; pushes one entry per byte-producing item into cscrw_queue.
`timescale 1ns / 1ps

module cscrw_front
  import cscrw_pkg::*;
#(
  parameter int DIM_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [7:0]   in_byte,
  input  logic         in_end_of_stream,
  input  logic         q_full,
  output logic         push,
  output cscrw_entry_t push_entry
);

  localparam int PROD_W = 2 * DIM_BITS;
  localparam int BL_W   = 2 * DIM_BITS - 3;
  localparam logic [DIM_BITS-1:0] DIM_MAX = '1;

  localparam logic [2:0] PH_SEARCH  = 3'd0;
  localparam logic [2:0] PH_CMD     = 3'd1;
  localparam logic [2:0] PH_PAYLOAD = 3'd2;
  localparam logic [2:0] PH_DATA    = 3'd3;
  localparam logic [2:0] PH_TRAILER = 3'd4;
  localparam logic [2:0] PH_DONE    = 3'd5;

  logic [31:0]         window_r, window_nxt;
  logic [2:0]          phase_r, phase_nxt;
  logic [3:0]          cmd_r, cmd_nxt;
  logic [3:0]          left_r, left_nxt;
  logic [31:0]         pval_r, pval_nxt;
  logic [DIM_BITS-1:0] width_r, width_nxt;
  logic [DIM_BITS-1:0] height_r, height_nxt;
  logic [PROD_W-1:0]   prod_r;
  logic [BL_W-1:0]     bl_r, bl_nxt;
  logic                bram_r, bram_nxt;
  logic                tnz_r, tnz_nxt;
  logic [1:0]          freq_r, freq_nxt;
  logic [1:0]          boot_r, boot_nxt;

  logic                accept;
  logic                exec;
  logic [3:0]          ex_cmd;
  logic [31:0]         ex_p;
  logic                run_go;
  logic                run_bram;
  logic [BL_W-1:0]     run_len;
  cscrw_entry_t        ent;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    window_nxt = window_r;
    phase_nxt  = phase_r;
    cmd_nxt    = cmd_r;
    left_nxt   = left_r;
    pval_nxt   = pval_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    bl_nxt     = bl_r;
    bram_nxt   = bram_r;
    tnz_nxt    = tnz_r;
    freq_nxt   = freq_r;
    boot_nxt   = boot_r;
    exec       = 1'b0;
    ex_cmd     = cmd_r;
    ex_p       = pval_r;
    run_go     = 1'b0;
    run_bram   = 1'b0;
    run_len    = '0;
    ent        = '0;
    ent.data   = in_byte;

    if (phase_r != PH_DONE) begin
      if (in_end_of_stream) begin
        ent.pad   = 1'b1;
        phase_nxt = PH_DONE;
      end else begin
        unique case (phase_r)
          PH_SEARCH: begin
            ent.echo   = 1'b1;
            window_nxt = {window_r[23:0], in_byte};
            if (window_nxt == PREAMBLE) phase_nxt = PH_CMD;
          end
          PH_CMD: begin
            ent.echo = 1'b1;
            cmd_nxt  = in_byte[7:4];
            left_nxt = in_byte[3:0];
            pval_nxt = '0;
            if (in_byte[3:0] == 4'd0) begin
              exec   = 1'b1;
              ex_cmd = in_byte[7:4];
              ex_p   = '0;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            pval_nxt = {pval_r[23:0], in_byte};
            ent.echo = (cmd_r != CMD_CRC);
            left_nxt = left_r - 4'd1;
            if (left_r == 4'd1) begin
              exec = 1'b1;
              ex_p = pval_nxt;
            end
          end
          PH_DATA: begin
            ent.echo = 1'b1;
            bl_nxt   = bl_r - 1'b1;
            if (bl_r == BL_W'(1)) begin
              bl_nxt    = BL_W'(2);
              phase_nxt = PH_TRAILER;
            end
          end
          PH_TRAILER: begin
            ent.echo = 1'b1;
            tnz_nxt  = tnz_r | (in_byte != 8'h00);
            bl_nxt   = bl_r - 1'b1;
            if (bl_r == BL_W'(1)) begin
              if (tnz_nxt) ent.warn = bram_r ? WARN_BRAM_TRL : WARN_CRAM_TRL;
              phase_nxt = PH_CMD;
            end
          end
          default: phase_nxt = PH_DONE;
        endcase
      end
    end

    // Execute a fully gathered command
    if (exec) begin
      phase_nxt = PH_CMD;
      unique case (ex_cmd) inside
        CMD_CONTROL: begin
          if (ex_p == CTL_CRAM) begin
            run_go = 1'b1;
          end else if (ex_p == CTL_BRAM) begin
            run_go   = 1'b1;
            run_bram = 1'b1;
          end else if (ex_p == CTL_CRC_RESET) begin
            ent.crc_rst = 1'b1;
          end else if (ex_p == CTL_WAKEUP) begin
            ent.pad   = 1'b1;
            phase_nxt = PH_DONE;
          end else begin
            ent.warn = WARN_BAD_CTL;
          end
        end
        CMD_BANK, CMD_OFFSET: ;
        CMD_CRC: begin
          ent.crc_hi = 1'b1;
          ent.crc_lo = 1'b1;
        end
        CMD_FREQ: begin
          if (ex_p > FREQ_MAX) ent.warn = WARN_BAD_FREQ;
          else                 freq_nxt = ex_p[1:0];
        end
        CMD_WIDTH: begin
          width_nxt = (ex_p >= 32'(DIM_MAX)) ? DIM_MAX : DIM_BITS'(ex_p + 32'd1);
        end
        CMD_HEIGHT: begin
          height_nxt = (ex_p > 32'(DIM_MAX)) ? DIM_MAX : ex_p[DIM_BITS-1:0];
        end
        CMD_FLAGS: begin
          if (ex_p == FLG_NONE)            boot_nxt = 2'b00;
          else if (ex_p == FLG_NOSLEEP)    boot_nxt = 2'b01;
          else if (ex_p == FLG_WARM)       boot_nxt = 2'b10;
          else if (ex_p == FLG_WARM_NOSLP) boot_nxt = 2'b11;
          else                             ent.warn = WARN_BAD_FLAGS;
        end
        default: ent.warn = WARN_BAD_CMD;
      endcase
    end

    // Start a CRAM or BRAM data run; BRAM moves whole 16-bit words
    if (run_go) begin
      run_len = prod_r[PROD_W-1:3];
      if (run_bram) run_len[0] = 1'b0;
      bram_nxt = run_bram;
      tnz_nxt  = 1'b0;
      if (run_len != '0) begin
        bl_nxt    = run_len;
        phase_nxt = PH_DATA;
      end else begin
        bl_nxt    = BL_W'(2);
        phase_nxt = PH_TRAILER;
      end
    end

    ent.freq      = freq_nxt;
    ent.warm_boot = boot_nxt[1];
    ent.no_sleep  = boot_nxt[0];
    ent.done      = (phase_nxt == PH_DONE);
  end

  assign push       = accept && (ent.echo || ent.crc_hi || ent.pad);
  assign push_entry = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      phase_r  <= PH_SEARCH;
      cmd_r    <= '0;
      left_r   <= '0;
      pval_r   <= '0;
      width_r  <= '0;
      height_r <= '0;
      prod_r   <= '0;
      bl_r     <= '0;
      bram_r   <= 1'b0;
      tnz_r    <= 1'b0;
      freq_r   <= '0;
      boot_r   <= '0;
    end else begin
      // Run size is registered from the dimension registers, so it lags them; a run command always needs
      // at least two more items after the last dimension update.
      prod_r <= PROD_W'(width_r) * PROD_W'(height_r);
      if (accept) begin
        window_r <= window_nxt;
        phase_r  <= phase_nxt;
        cmd_r    <= cmd_nxt;
        left_r   <= left_nxt;
        pval_r   <= pval_nxt;
        width_r  <= width_nxt;
        height_r <= height_nxt;
        bl_r     <= bl_nxt;
        bram_r   <= bram_nxt;
        tnz_r    <= tnz_nxt;
        freq_r   <= freq_nxt;
        boot_r   <= boot_nxt;
      end
    end
  end

endmodule

>>> rtl/cscrw_back.sv
// Back part: expands queued entries into output bytes and keeps the output CRC.
// Depends on cscrw_pkg; reads entries from cscrw_queue.
`timescale 1ns / 1ps

module cscrw_back
  import cscrw_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  cscrw_entry_t head,
  input  logic         q_empty,
  output logic         pop,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [7:0]   out_byte,
  output logic         out_last_of_run,
  output logic [2:0]   out_warning,
  output logic [1:0]   out_freq_range,
  output logic         out_warm_boot,
  output logic         out_no_sleep,
  output logic         out_stream_done
);

  cscrw_entry_t cur_r, cur_nxt;
  logic         active_r;
  logic [15:0]  crc_r, crc_nxt;
  logic [7:0]   crc_lo_r;
  logic         out_valid_r;
  logic [7:0]   byte_r, byte_nxt;
  logic         last_r, last_nxt;
  logic [2:0]   warn_r;
  logic [1:0]   freq_r;
  logic         warm_r, nosleep_r, done_r;

  cscrw_entry_t src;
  logic         src_valid;
  logic         load;

  assign src       = active_r ? cur_r : head;
  assign src_valid = active_r || !q_empty;
  assign load      = src_valid && (!out_valid_r || out_ready);
  assign pop       = load && !active_r;

  // Pick the next byte in the order echo, CRC high, CRC low, pad
  always_comb begin
    cur_nxt  = src;
    byte_nxt = 8'h00;
    crc_nxt  = crc_r;
    if (src.echo) begin
      cur_nxt.echo = 1'b0;
      byte_nxt     = src.data;
      crc_nxt      = src.crc_rst ? CRC_INIT : crc_byte(crc_r, src.data);
    end else if (src.crc_hi) begin
      cur_nxt.crc_hi = 1'b0;
      byte_nxt       = crc_r[15:8];
      crc_nxt        = crc_byte(crc_r, crc_r[15:8]);
    end else if (src.crc_lo) begin
      cur_nxt.crc_lo = 1'b0;
      byte_nxt       = crc_lo_r;
      crc_nxt        = crc_byte(crc_r, crc_lo_r);
    end else begin
      cur_nxt.pad = 1'b0;
      crc_nxt     = crc_byte(crc_r, 8'h00);
    end
    last_nxt = !(cur_nxt.echo || cur_nxt.crc_hi || cur_nxt.crc_lo || cur_nxt.pad);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r     <= cur_nxt;
      byte_r    <= byte_nxt;
      last_r    <= last_nxt;
      warn_r    <= src.warn;
      freq_r    <= src.freq;
      warm_r    <= src.warm_boot;
      nosleep_r <= src.no_sleep;
      done_r    <= src.done;
      // Hold the low byte of the CRC as it stood before the high byte went out
      if (!src.echo && src.crc_hi) crc_lo_r <= crc_r[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      crc_r       <= '0;
    end else begin
      if (load) begin
        active_r    <= !last_nxt;
        out_valid_r <= 1'b1;
        crc_r       <= crc_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = byte_r;
  assign out_last_of_run = last_r;
  assign out_warning     = warn_r;
  assign out_freq_range  = freq_r;
  assign out_warm_boot   = warm_r;
  assign out_no_sleep    = nosleep_r;
  assign out_stream_done = done_r;

endmodule

>>> rtl/fpga_config_stream_crc_rewriter.sv
// Top level of the configuration stream CRC rewriter.
// Depends on cscrw_pkg, cscrw_front, cscrw_queue and cscrw_back.
`timescale 1ns / 1ps
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  in       | in_valid / in_ready   | in_byte[7:0], in_end_of_stream
//  out      | out_valid / out_ready | out_byte[7:0], out_last_of_run,
//           |                       | out_warning[2:0], out_freq_range[1:0],
//           |                       | out_warm_boot, out_no_sleep, out_stream_done
//
//  The front takes one item per cycle while the four-entry queue has room.
//  The back sends one output byte per cycle while out_ready is high; an item that makes
//  two or three bytes (CRC command, wakeup) holds the back until all its bytes are out,
//  so sustained throughput is set by the single output port.
//  An accepted item is written into the queue; its first output byte is then registered in the back.
//  rst_n is synchronous, active low, and clears the queue, state and CRC.
//  A stalled out_ready backs up the queue and then drops in_ready.
//
module fpga_config_stream_crc_rewriter
  import cscrw_pkg::*;
#(
  parameter int DIM_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_stream,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last_of_run,
  output logic [2:0] out_warning,
  output logic [1:0] out_freq_range,
  output logic       out_warm_boot,
  output logic       out_no_sleep,
  output logic       out_stream_done
);

  cscrw_entry_t push_entry;
  cscrw_entry_t head;
  logic         push;
  logic         pop;
  logic         q_empty;
  logic         q_full;

  // Classify each byte and decide which output bytes it causes
  cscrw_front #(
    .DIM_BITS(DIM_BITS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .in_end_of_stream (in_end_of_stream),
    .q_full           (q_full),
    .push             (push),
    .push_entry       (push_entry)
  );

  // Decouple decode from output so each side stalls on its own
  cscrw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty),
    .full       (q_full)
  );

  // Serialize bytes, insert CRC, keep the running output CRC
  cscrw_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .q_empty         (q_empty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run),
    .out_warning     (out_warning),
    .out_freq_range  (out_freq_range),
    .out_warm_boot   (out_warm_boot),
    .out_no_sleep    (out_no_sleep),
    .out_stream_done (out_stream_done)
  );

endmodule

>>> rtl/cscrw_checker.sv
// Port-level checks for the config stream CRC rewriter, bound to the top level.
// Depends on cscrw_pkg for warning codes.
`timescale 1ns / 1ps

module cscrw_checker
  import cscrw_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last_of_run,
  input logic [2:0] out_warning,
  input logic       out_stream_done
);

  // Reset empties the output stage
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last_of_run))
    else $error("stalled output changed");

  // The final byte of a finished stream is the zero pad
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stream_done && out_last_of_run |-> out_byte == 8'h00)
    else $error("pad byte is not zero");

  // Nothing follows the pad byte
  a_silent_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_stream_done && out_last_of_run |=> !out_valid)
    else $error("output after stream done");

  // Trailer warnings come on single-byte items
  a_trailer_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_warning == WARN_CRAM_TRL || out_warning == WARN_BRAM_TRL)
    |-> out_last_of_run)
    else $error("trailer warning on non-final byte");

endmodule

bind fpga_config_stream_crc_rewriter cscrw_checker u_cscrw_checker (.*);
